/* hdl/fbsa_pkg.sv */
// Shared constants, types and codes for the fixed-size block allocator.
// No dependencies; compiled first.
package fbsa_pkg;

  localparam int BLOCK_COUNT_DEF = 256;
  localparam int BLOCK_BYTES_DEF = 4096;
  localparam int ALIGN_BYTES_DEF = 8;

  localparam int ADDR_W     = 32;
  localparam int SIZE_W     = 32;
  localparam int KIND_W     = 2;
  localparam int STATUS_W   = 3;
  localparam int FREE_W     = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  typedef logic [KIND_W-1:0]    kind_t;
  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam kind_t KIND_ALLOC  = 2'd0;
  localparam kind_t KIND_FREE   = 2'd1;
  localparam kind_t KIND_REINIT = 2'd2;

  localparam status_t ST_OK             = 3'd0;
  localparam status_t ST_EXHAUSTED      = 3'd1;
  localparam status_t ST_TOO_LARGE      = 3'd2;
  localparam status_t ST_OUT_OF_REGION  = 3'd3;
  localparam status_t ST_NONE_ALLOCATED = 3'd4;

  localparam cfg_idx_t REG_RAW_BASE    = 1'b0;
  localparam cfg_idx_t REG_REGION_SIZE = 1'b1;

endpackage

/* hdl/fbsa_if.sv */
// Request and response channel interfaces of the block allocator.
// Depends on fbsa_pkg.
interface fbsa_req_if;
  import fbsa_pkg::*;
  logic              valid;
  logic              ready;
  kind_t             kind;
  logic [SIZE_W-1:0] request_size;
  logic [ADDR_W-1:0] free_address;

  modport source (output valid, kind, request_size, free_address, input ready);
  modport sink   (input valid, kind, request_size, free_address, output ready);
endinterface

interface fbsa_rsp_if;
  import fbsa_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] block_address;
  status_t           status;
  logic [FREE_W-1:0] free_blocks;

  modport source (output valid, block_address, status, free_blocks, input ready);
  modport sink   (input valid, block_address, status, free_blocks, output ready);
endinterface

/* hdl/fbsa_stack_mem.sv */
// Free-address stack storage: one write port, one registered read port.
// Depends on fbsa_pkg.
module fbsa_stack_mem #(
  parameter int DEPTH = fbsa_pkg::BLOCK_COUNT_DEF,
  parameter int IDX_W = 8
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [IDX_W-1:0]          wr_idx,
  input  logic [fbsa_pkg::ADDR_W-1:0] wr_data,
  input  logic [IDX_W-1:0]          rd_idx,
  output logic [fbsa_pkg::ADDR_W-1:0] rd_data
);
  import fbsa_pkg::*;

  logic [ADDR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_idx];
  end

endmodule

/* hdl/fixed_block_free_stack_allocator_top.sv */
// Fixed-size block allocator: control, stack pointer and result register.
// Depends on fbsa_pkg, fbsa_if and fbsa_stack_mem.
// Free, failed allocate and unused kinds register their word on acceptance; a
// successful allocate first reads the stack memory, then registers its word.
// Reinitialize aligns the base (digit fold, reciprocal multiply, remainder), then
// fills every stack memory entry in a sweep; its word is registered at the end.
// One item at a time: a request is taken only when idle and the last word is taken.
// Reset clears control, config and pool bounds; stack contents are not cleared.
module fixed_block_free_stack_allocator_top #(
  parameter int BLOCK_COUNT = fbsa_pkg::BLOCK_COUNT_DEF,
  parameter int BLOCK_BYTES = fbsa_pkg::BLOCK_BYTES_DEF,
  parameter int ALIGN_BYTES = fbsa_pkg::ALIGN_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  fbsa_pkg::cfg_idx_t            cfg_index,
  input  logic [fbsa_pkg::CFG_DATA_W-1:0] cfg_data,
  fbsa_req_if.sink                      req,
  fbsa_rsp_if.source                    rsp
);
  import fbsa_pkg::*;

  localparam int IDX_W   = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
  localparam int TOP_W   = $clog2(BLOCK_COUNT + 1);
  localparam int ALIGN_L = $clog2(ALIGN_BYTES);
  localparam int RED_N   = 28;
  localparam int RED_S   = RED_N + ALIGN_L;
  localparam int RECIP_W = 30;
  localparam int PROD_W  = RED_N + RECIP_W;

  localparam longint RECIP  = ((longint'(1) << RED_S) + longint'(ALIGN_BYTES) - longint'(1))
                              / longint'(ALIGN_BYTES);
  localparam longint WRAP16 = (longint'(1) << 16) % longint'(ALIGN_BYTES);

  localparam logic [TOP_W-1:0]   TOP_FULL    = TOP_W'(BLOCK_COUNT);
  localparam logic [IDX_W-1:0]   IDX_LAST    = IDX_W'(BLOCK_COUNT - 1);
  localparam logic [RECIP_W-1:0] RECIP_C     = RECIP_W'(RECIP);
  localparam logic [RED_N-1:0]   WRAP_C      = RED_N'(WRAP16);
  localparam logic [RED_N-1:0]   ALIGN_N     = RED_N'(ALIGN_BYTES);
  localparam logic [ADDR_W-1:0]  ALIGN_A     = ADDR_W'(ALIGN_BYTES);
  localparam logic [ADDR_W-1:0]  BLOCK_STEP  = ADDR_W'(BLOCK_BYTES);
  localparam logic [SIZE_W-1:0]  BLOCK_LIMIT = SIZE_W'(BLOCK_BYTES);
  localparam logic [1:0]         PHASE_LAST  = 2'd2;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_ALIGN = 2'd2;
  localparam logic [1:0] S_SWEEP = 2'd3;

  function automatic logic [FREE_W-1:0] free_count(input logic [TOP_W-1:0] t);
    logic [31:0] d;
    d = 32'(BLOCK_COUNT) - 32'(t);
    return d[FREE_W-1:0];
  endfunction

  logic [1:0]        state, state_next;
  logic [TOP_W-1:0]  top, top_next, top_dec;
  logic [ADDR_W-1:0] raw_base, region_size, size_lat, base;
  logic [RED_N-1:0]  red_sum, red_q, red_rem;
  logic [PROD_W-1:0] red_prod;
  logic [1:0]        phase;
  logic [IDX_W-1:0]  fill_idx;
  logic [ADDR_W-1:0] fill_addr, aligned;
  logic              out_valid;
  logic [ADDR_W-1:0] out_addr;
  status_t           out_status;
  logic [FREE_W-1:0] out_free;

  logic              accept, in_region;
  logic [ADDR_W:0]   region_hi;
  logic              res_load;
  logic [ADDR_W-1:0] res_addr;
  status_t           res_status;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  logic [ADDR_W-1:0] wr_data, rd_data;

  assign req.ready = (state == S_IDLE) && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  assign top_dec   = top - 1'b1;
  assign region_hi = {1'b0, base} + {1'b0, size_lat};
  assign in_region = (req.free_address >= base) && ({1'b0, req.free_address} <= region_hi);

  assign red_prod = PROD_W'(red_sum) * PROD_W'(RECIP_C);
  assign aligned  = (red_rem == '0) ? raw_base : raw_base + (ALIGN_A - ADDR_W'(red_rem));

  always_comb begin
    state_next = state;
    top_next   = top;
    res_load   = 1'b0;
    res_addr   = '0;
    res_status = ST_OK;
    wr_en      = 1'b0;
    wr_idx     = fill_idx;
    wr_data    = fill_addr;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req.kind)
            KIND_ALLOC: begin
              if (top == TOP_FULL) begin
                res_load   = 1'b1;
                res_status = ST_EXHAUSTED;
              end else if (req.request_size > BLOCK_LIMIT) begin
                res_load   = 1'b1;
                res_status = ST_TOO_LARGE;
              end else begin
                top_next   = top + 1'b1;
                state_next = S_READ;
              end
            end
            KIND_FREE: begin
              res_load = 1'b1;
              if (!in_region) begin
                res_status = ST_OUT_OF_REGION;
              end else if (top == '0) begin
                res_status = ST_NONE_ALLOCATED;
              end else begin
                top_next = top_dec;
                wr_en    = 1'b1;
                wr_idx   = top_dec[IDX_W-1:0];
                wr_data  = req.free_address;
              end
            end
            KIND_REINIT: begin
              top_next   = '0;
              state_next = S_ALIGN;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        res_load   = 1'b1;
        res_addr   = rd_data;
        state_next = S_IDLE;
      end
      S_ALIGN: begin
        if (phase == PHASE_LAST) begin
          state_next = S_SWEEP;
        end
      end
      S_SWEEP: begin
        wr_en = 1'b1;
        if (fill_idx == IDX_LAST) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      top         <= '0;
      out_valid   <= 1'b0;
      raw_base    <= '0;
      region_size <= '0;
      size_lat    <= '0;
      base        <= '0;
    end else begin
      state <= state_next;
      top   <= top_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_RAW_BASE:    raw_base    <= cfg_data;
          REG_REGION_SIZE: region_size <= cfg_data;
          default: ;
        endcase
      end
      if (accept && req.kind == KIND_REINIT) begin
        size_lat <= region_size;
      end
      if (state == S_ALIGN && phase == PHASE_LAST) begin
        base <= aligned;
      end
    end
  end

  // Alignment remainder, fill pointer and result payload.
  always_ff @(posedge clk) begin
    if (accept && req.kind == KIND_REINIT) begin
      red_sum <= RED_N'(raw_base[ADDR_W-1:16]) * WRAP_C + RED_N'(raw_base[15:0]);
      phase   <= '0;
    end else if (state == S_ALIGN) begin
      red_q   <= RED_N'(red_prod >> RED_S);
      red_rem <= red_sum - red_q * ALIGN_N;
      phase   <= phase + 1'b1;
    end
    if (state == S_ALIGN) begin
      fill_idx  <= '0;
      fill_addr <= aligned;
    end else if (state == S_SWEEP) begin
      fill_idx  <= fill_idx + 1'b1;
      fill_addr <= fill_addr + BLOCK_STEP;
    end
    if (res_load) begin
      out_addr   <= res_addr;
      out_status <= res_status;
      out_free   <= free_count(top_next);
    end
  end

  fbsa_stack_mem #(
    .DEPTH (BLOCK_COUNT),
    .IDX_W (IDX_W)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_idx  (wr_idx),
    .wr_data (wr_data),
    .rd_idx  (top[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  assign rsp.valid         = out_valid;
  assign rsp.block_address = out_addr;
  assign rsp.status        = out_status;
  assign rsp.free_blocks   = out_free;

endmodule

/* hdl/fbsa_checker.sv */
// Port-level checks of the block allocator, bound to the top level.
// Depends on fbsa_pkg and fixed_block_free_stack_allocator_top.
module fbsa_checker #(
  parameter int BLOCK_COUNT = fbsa_pkg::BLOCK_COUNT_DEF
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            rsp_valid,
  input logic                            rsp_ready,
  input logic [fbsa_pkg::ADDR_W-1:0]     rsp_block_address,
  input fbsa_pkg::status_t               rsp_status,
  input logic [fbsa_pkg::FREE_W-1:0]     rsp_free_blocks
);
  import fbsa_pkg::*;

  localparam logic [31:0]       COUNT_32  = 32'(BLOCK_COUNT);
  localparam logic [FREE_W-1:0] FREE_FULL = COUNT_32[FREE_W-1:0];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_block_address))
    else $error("stalled response word dropped or changed");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_OK |-> rsp_block_address == '0)
    else $error("failed item returned a nonzero address");

  a_exhausted: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_EXHAUSTED |-> rsp_free_blocks == '0)
    else $error("pool exhausted with free blocks left");

  a_none_alloc: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_NONE_ALLOCATED |-> rsp_free_blocks == FREE_FULL)
    else $error("free refused while blocks are allocated");

endmodule

bind fixed_block_free_stack_allocator_top fbsa_checker #(
  .BLOCK_COUNT (BLOCK_COUNT)
) u_fbsa_checker (
  .clk               (clk),
  .rst               (rst),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_block_address (rsp.block_address),
  .rsp_status        (rsp.status),
  .rsp_free_blocks   (rsp.free_blocks)
);

/* dv/fbsa_reply_checker.sv */
// Reply checker for the fixed-size block allocator: follows the config port and both
// channels, keeps its own copy of the free stack, predicts each reply and compares.
// Depends on fbsa_pkg and fbsa_if.
`timescale 1ns / 1ps
module fbsa_reply_checker #(
  parameter int BLOCK_COUNT = fbsa_pkg::BLOCK_COUNT_DEF,
  parameter int BLOCK_BYTES = fbsa_pkg::BLOCK_BYTES_DEF,
  parameter int ALIGN_BYTES = fbsa_pkg::ALIGN_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  fbsa_pkg::cfg_idx_t              cfg_index,
  input  logic [fbsa_pkg::CFG_DATA_W-1:0] cfg_data,
  fbsa_req_if                             req,
  fbsa_rsp_if                             rsp,
  output int                              mismatches,
  output int                              awaiting
);
  import fbsa_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0] block_address;
    status_t           status;
    logic [FREE_W-1:0] free_blocks;
  } alloc_reply_t;

  alloc_reply_t      replies_due[$];
  logic [ADDR_W-1:0] raw_base;
  logic [SIZE_W-1:0] region_bytes;
  logic [ADDR_W-1:0] pool_base;
  logic [SIZE_W-1:0] pool_bytes;
  bit   [ADDR_W-1:0] free_slots[BLOCK_COUNT];
  bit                slot_valid[BLOCK_COUNT];
  int                stack_top;
  int                fault_count = 0;

  function automatic alloc_reply_t predict_reply(input kind_t k,
                                                 input logic [SIZE_W-1:0] ask,
                                                 input logic [ADDR_W-1:0] addr);
    alloc_reply_t     r;
    logic [ADDR_W:0]   bound;
    logic [ADDR_W+1:0] rounded;
    r.block_address = '0;
    r.status = ST_OK;
    case (k)
      KIND_ALLOC: begin
        if (stack_top >= BLOCK_COUNT) begin
          r.status = ST_EXHAUSTED;
        end else if (ask > SIZE_W'(BLOCK_BYTES)) begin
          r.status = ST_TOO_LARGE;
        end else begin
          r.block_address = slot_valid[stack_top] ? free_slots[stack_top] : '0;
          stack_top++;
        end
      end
      KIND_FREE: begin
        bound = {1'b0, pool_base} + {1'b0, pool_bytes};
        if (addr < pool_base || {1'b0, addr} > bound) begin
          r.status = ST_OUT_OF_REGION;
        end else if (stack_top == 0) begin
          r.status = ST_NONE_ALLOCATED;
        end else begin
          stack_top--;
          free_slots[stack_top] = addr;
          slot_valid[stack_top] = 1'b1;
        end
      end
      KIND_REINIT: begin
        rounded = {2'b00, raw_base} + (ALIGN_BYTES - 1);
        pool_base = ADDR_W'(rounded - rounded % ALIGN_BYTES);
        pool_bytes = region_bytes;
        stack_top = 0;
        for (int i = 0; i < BLOCK_COUNT; i++) begin
          free_slots[i] = pool_base + ADDR_W'(longint'(i) * BLOCK_BYTES);
          slot_valid[i] = 1'b1;
        end
      end
      default: ;
    endcase
    r.free_blocks = FREE_W'(BLOCK_COUNT - stack_top);
    return r;
  endfunction

  task automatic log_fault(input string what, input alloc_reply_t want,
                           input alloc_reply_t seen);
    fault_count++;
    if (fault_count <= 10)
      $display("%0t %s: want addr=%h status=%0d free=%0d, got addr=%h status=%0d free=%0d",
               $time, what, want.block_address, want.status, want.free_blocks,
               seen.block_address, seen.status, seen.free_blocks);
  endtask

  always @(posedge clk) begin : watch
    alloc_reply_t seen;
    alloc_reply_t want;
    if (rst) begin
      raw_base = '0;
      region_bytes = '0;
      pool_base = '0;
      pool_bytes = '0;
      stack_top = 0;
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
      replies_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_RAW_BASE) raw_base = cfg_data;
        else region_bytes = cfg_data;
      end
      if (rsp.valid && rsp.ready) begin
        seen.block_address = rsp.block_address;
        seen.status = rsp.status;
        seen.free_blocks = rsp.free_blocks;
        if (replies_due.size() == 0) begin
          log_fault("reply with nothing due", '0, seen);
        end else begin
          want = replies_due.pop_front();
          if (seen !== want) log_fault("reply mismatch", want, seen);
        end
      end
      if (req.valid && req.ready)
        replies_due.push_back(predict_reply(req.kind, req.request_size, req.free_address));
    end
    awaiting <= replies_due.size();
    mismatches <= fault_count;
  end

endmodule

/* dv/fixed_block_free_stack_allocator_top_test.sv */
// Top of the block allocator test: clock, reset, config writes, request and reply
// traffic with random gaps. Depends on fbsa_pkg, fbsa_if, the allocator top and
// fbsa_reply_checker.
`timescale 1ns / 1ps
module fixed_block_free_stack_allocator_top_test;
  import fbsa_pkg::*;

  localparam int    BLOCKS      = BLOCK_COUNT_DEF;
  localparam int    BYTES       = BLOCK_BYTES_DEF;
  localparam int    ALIGN       = ALIGN_BYTES_DEF;
  localparam int    WORD_TARGET = 1300;
  localparam int    CYCLE_LIMIT = 1_000_000;
  localparam kind_t KIND_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  cfg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  hold_off = 1'b0;
  logic                  steady = 1'b0;
  int                    words_sent = 0;
  int                    cycle_count = 0;
  int                    held = 0;
  int                    mismatches;
  int                    awaiting;
  logic [ADDR_W-1:0]     cfg_base = '0;
  logic [SIZE_W-1:0]     cfg_size = '0;
  logic [ADDR_W-1:0]     pool_lo = '0;
  logic [ADDR_W:0]       pool_hi = '0;

  fbsa_req_if req ();
  fbsa_rsp_if rsp ();

  fixed_block_free_stack_allocator_top #(
    .BLOCK_COUNT(BLOCKS),
    .BLOCK_BYTES(BYTES),
    .ALIGN_BYTES(ALIGN)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req(req),
    .rsp(rsp)
  );

  fbsa_reply_checker #(
    .BLOCK_COUNT(BLOCKS),
    .BLOCK_BYTES(BYTES),
    .ALIGN_BYTES(ALIGN)
  ) reply_check (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req(req),
    .rsp(rsp),
    .mismatches(mismatches),
    .awaiting(awaiting)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int pause_len();
    int pick;
    pick = $urandom_range(99, 0);
    if (steady || pick < 55) return 0;
    if (pick < 88) return $urandom_range(3, 1);
    if (pick < 97) return $urandom_range(12, 4);
    return $urandom_range(40, 20);
  endfunction

  function automatic logic [SIZE_W-1:0] request_bytes();
    case ($urandom_range(9, 0))
      0: return $urandom;
      1: return SIZE_W'(BYTES + $urandom_range(1, 0));
      default: return $urandom_range(BYTES, 0);
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] region_address();
    longint span;
    longint off;
    span = pool_hi[ADDR_W] ? longint'(32'hFFFF_FFFF - pool_lo)
                           : longint'(pool_hi[ADDR_W-1:0] - pool_lo);
    case ($urandom_range(5, 0))
      0: off = 0;
      1: off = span;
      2, 3: off = longint'($urandom_range(BLOCKS - 1, 0)) * BYTES;
      default: off = $urandom;
    endcase
    return pool_lo + ADDR_W'(off % (span + 1));
  endfunction

  task automatic send_word(input kind_t k, input logic [SIZE_W-1:0] ask,
                           input logic [ADDR_W-1:0] addr);
    int                gap;
    logic [ADDR_W+1:0] rounded;
    req.valid <= 1'b1;
    req.kind <= k;
    req.request_size <= ask;
    req.free_address <= addr;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    words_sent++;
    case (k)
      KIND_ALLOC: if (held < BLOCKS && ask <= SIZE_W'(BYTES)) held++;
      KIND_FREE: if (addr >= pool_lo && {1'b0, addr} <= pool_hi && held > 0) held--;
      KIND_REINIT: begin
        rounded = {2'b00, cfg_base} + (ALIGN - 1);
        pool_lo = ADDR_W'(rounded - rounded % ALIGN);
        pool_hi = {1'b0, pool_lo} + {1'b0, cfg_size};
        held = 0;
      end
      default: ;
    endcase
    gap = pause_len();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_config(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] bytes);
    req.valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_RAW_BASE;
    cfg_data <= base;
    @(posedge clk);
    cfg_index <= REG_REGION_SIZE;
    cfg_data <= bytes;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_base = base;
    cfg_size = bytes;
  endtask

  initial begin : reply_side
    int stall;
    stall = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off || stall > 0) begin
        rsp.ready <= 1'b0;
        if (stall > 0) stall--;
      end else begin
        rsp.ready <= 1'b1;
        if (!steady && $urandom_range(3, 0) == 0) stall = pause_len();
      end
    end
  end

  initial begin : back_pressure
    wait (words_sent >= 400);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin : stimulus
    logic [ADDR_W-1:0] base;
    logic [SIZE_W-1:0] bytes;
    int                count;
    int                drains;
    int                pick;
    drains = 0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_RAW_BASE;
    cfg_data <= '0;
    req.valid <= 1'b0;
    req.kind <= KIND_ALLOC;
    req.request_size <= '0;
    req.free_address <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    write_config(32'h0000_1001, 32'h0010_0000);
    send_word(KIND_REINIT, $urandom, $urandom);
    send_word(KIND_ALLOC, 32'd0, $urandom);
    send_word(KIND_ALLOC, SIZE_W'(BYTES), $urandom);
    send_word(KIND_ALLOC, SIZE_W'(BYTES + 1), $urandom);
    send_word(KIND_ALLOC, 32'hFFFF_FFFF, $urandom);
    send_word(KIND_FREE, $urandom, 32'h0000_1007);
    send_word(KIND_FREE, $urandom, 32'h0010_1009);
    send_word(KIND_FREE, $urandom, 32'h0010_1008);
    send_word(KIND_FREE, $urandom, 32'h0000_1008);
    send_word(KIND_FREE, $urandom, 32'h0000_1008);
    send_word(KIND_UNUSED, $urandom, $urandom);
    send_word(KIND_FREE, 32'h0, 32'hFFFF_FFFF);
    send_word(KIND_ALLOC, 32'd1, 32'h0);
    send_word(KIND_ALLOC, 32'd2, 32'hFFFF_FFFF);

    write_config(32'hFFFF_F001, 32'hFFFF_FFFF);
    send_word(KIND_REINIT, $urandom, $urandom);
    send_word(KIND_ALLOC, $urandom_range(BYTES, 0), $urandom);
    send_word(KIND_ALLOC, $urandom_range(BYTES, 0), $urandom);
    send_word(KIND_FREE, $urandom, 32'hFFFF_FFFF);
    send_word(KIND_FREE, $urandom, 32'hFFFF_F007);

    write_config(32'hFFFF_FFFF, 32'h0);
    send_word(KIND_REINIT, $urandom, $urandom);
    send_word(KIND_ALLOC, 32'd1, $urandom);
    send_word(KIND_FREE, $urandom, 32'h0);
    send_word(KIND_FREE, $urandom, 32'h1);
    send_word(KIND_FREE, $urandom, 32'h0);

    while (words_sent < WORD_TARGET) begin
      case ($urandom_range(5, 0))
        0: base = '0;
        1: base = '1;
        2: base = 32'hFFFF_FFF8 - $urandom_range(15, 0);
        3: base = 32'hFFFF_F000 + $urandom_range(4095, 0);
        default: base = $urandom;
      endcase
      case ($urandom_range(5, 0))
        0: bytes = '0;
        1: bytes = '1;
        2: bytes = SIZE_W'(BLOCKS * BYTES);
        3: bytes = $urandom_range(65535, 0);
        default: bytes = $urandom;
      endcase
      steady <= ($urandom_range(4, 0) == 0);
      write_config(base, bytes);
      send_word(KIND_REINIT, $urandom, $urandom);
      if (drains == 0 || $urandom_range(2, 0) == 0) begin
        drains++;
        while (held < BLOCKS) send_word(KIND_ALLOC, request_bytes(), $urandom);
        repeat ($urandom_range(4, 1)) send_word(KIND_ALLOC, request_bytes(), $urandom);
        send_word(KIND_ALLOC, $urandom | 32'h8000_0000, $urandom);
        repeat ($urandom_range(40, 10)) send_word(KIND_FREE, $urandom, region_address());
      end else begin
        count = $urandom_range(120, 40);
        for (int n = 0; n < count; n++) begin
          if (n == count / 2 && $urandom_range(2, 0) == 0) write_config($urandom, $urandom);
          pick = $urandom_range(99, 0);
          if (pick < 45 || (held == 0 && pick < 75))
            send_word(KIND_ALLOC, request_bytes(), $urandom);
          else if (pick < 85)
            send_word(KIND_FREE, $urandom, region_address());
          else if (pick < 95)
            send_word(KIND_FREE, $urandom, $urandom);
          else if (pick < 98)
            send_word(KIND_UNUSED, $urandom, $urandom);
          else
            send_word(KIND_REINIT, $urandom, $urandom);
        end
      end
    end

    req.valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && awaiting == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/fbsa_pkg.sv
hdl/fbsa_if.sv
hdl/fbsa_stack_mem.sv
hdl/fixed_block_free_stack_allocator_top.sv
hdl/fbsa_checker.sv
dv/fbsa_reply_checker.sv
dv/fixed_block_free_stack_allocator_top_test.sv
